FILE: hdl/wspm_pkg.sv
// ----------------------------------------------------------------------------
// wspm_pkg
// Shared types and constants for the weighted segment position mapper.
// ----------------------------------------------------------------------------
package wspm_pkg;

   localparam int MAX_SEGMENTS_DEF = 1024;
   localparam int POS_BITS_DEF     = 32;
   localparam int TOTAL_BITS_DEF   = 48;

   localparam int CHROM_W  = 8;
   localparam int PPOS_W   = 32;
   localparam int CN_W     = 8;
   localparam int PTOT_W   = 48;
   localparam int STATUS_W = 3;
   localparam int SEGNUM_W = 10;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_MAP = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED    = 3'd0,
      STAT_MAPPED   = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_EMPTY    = 3'd3,
      STAT_BEYOND   = 3'd4,
      STAT_OVERFLOW = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_MUL,
      ST_ADD_CHK,
      ST_SRCH,
      ST_SRCH_CMP,
      ST_FETCH,
      ST_DIV,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic               command;
      logic [CHROM_W-1:0] chrom_index;
      logic [PPOS_W-1:0]  seg_begin;
      logic [PPOS_W-1:0]  seg_finish;
      logic [CN_W-1:0]    copy_number;
      logic [PTOT_W-1:0]  weighted_pos;
      logic               empty;
   } item_type;

endpackage

FILE: hdl/wspm_if.sv
// ----------------------------------------------------------------------------
// wspm_req_if / wspm_rsp_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface wspm_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [wspm_pkg::CHROM_W-1:0]  chrom_index;
   logic [wspm_pkg::PPOS_W-1:0]   seg_begin;
   logic [wspm_pkg::PPOS_W-1:0]   seg_finish;
   logic [wspm_pkg::CN_W-1:0]     copy_number;
   logic [wspm_pkg::PTOT_W-1:0]   weighted_pos;

   modport source (output valid, command, chrom_index, seg_begin, seg_finish,
                   copy_number, weighted_pos, input ready);
   modport sink (input valid, command, chrom_index, seg_begin, seg_finish,
                 copy_number, weighted_pos, output ready);
endinterface

interface wspm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [wspm_pkg::STATUS_W-1:0]  status;
   logic [wspm_pkg::SEGNUM_W-1:0]  segment_number;
   logic [wspm_pkg::CHROM_W-1:0]   out_chrom;
   logic [wspm_pkg::PPOS_W-1:0]    plain_pos;
   logic [wspm_pkg::PTOT_W-1:0]    weighted_total;

   modport source (output valid, status, segment_number, out_chrom, plain_pos,
                   weighted_total, input ready);
   modport sink (input valid, status, segment_number, out_chrom, plain_pos,
                 weighted_total, output ready);
endinterface

FILE: hdl/weighted_segment_position_mapper.sv
// ----------------------------------------------------------------------------
// weighted_segment_position_mapper
// Segment table with weighted totals; appends segments and maps positions.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command per transaction: command 0 appends a
//   segment (chrom_index, seg_begin, seg_finish, copy_number), command 1
//   maps weighted_pos back to a chromosome and base. rsp_chan returns one
//   result transaction per command, in order.
//   A front queue of two entries takes commands while the back end works.
//   An error decided on arrival goes straight to the result; an append
//   passes a multiply and an overflow check; a map runs a binary search,
//   a fetch and the remainder divide. The binary search reads
//   the segment memory once per step, and the remainder unit retires one
//   dividend bit per cycle; one command is in the back end at a time.
//   Reset empties the table and zeroes the running total; the memory
//   itself is not cleared. When the receiver stalls, the result is held
//   in the output register, the back end waits, and req_chan.ready drops
//   once the queue is full.
// ----------------------------------------------------------------------------
module weighted_segment_position_mapper #(
   parameter int MAX_SEGMENTS = wspm_pkg::MAX_SEGMENTS_DEF,
   parameter int POS_BITS     = wspm_pkg::POS_BITS_DEF,
   parameter int TOTAL_BITS   = wspm_pkg::TOTAL_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   wspm_req_if.sink    req_chan,
   wspm_rsp_if.source  rsp_chan
);

   logic               q_valid;
   logic               q_pop;
   wspm_pkg::item_type q_item;

   wspm_front #(
      .POS_BITS (POS_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   wspm_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .POS_BITS     (POS_BITS),
      .TOTAL_BITS   (TOTAL_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: hdl/wspm_front.sv
// ----------------------------------------------------------------------------
// wspm_front
// Accepts command transactions, flags empty intervals and queues them.
// ----------------------------------------------------------------------------
module wspm_front #(
   parameter int POS_BITS = wspm_pkg::POS_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   wspm_req_if.sink            req_chan,
   output logic                q_valid,
   output wspm_pkg::item_type  q_item,
   input  logic                q_pop
);

   wspm_pkg::item_type  slot_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                push;
   logic [POS_BITS-1:0] b_m, f_m;
   wspm_pkg::item_type  new_item;

   assign b_m = POS_BITS'(req_chan.seg_begin);
   assign f_m = POS_BITS'(req_chan.seg_finish);

   always_comb begin
      new_item.command      = req_chan.command;
      new_item.chrom_index  = req_chan.chrom_index;
      new_item.seg_begin    = req_chan.seg_begin;
      new_item.seg_finish   = req_chan.seg_finish;
      new_item.copy_number  = req_chan.copy_number;
      new_item.weighted_pos = req_chan.weighted_pos;
      new_item.empty        = (f_m <= b_m);
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != 2'd0);
   assign q_item         = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: hdl/wspm_back.sv
// ----------------------------------------------------------------------------
// wspm_back
// Executes queued commands: segment append, binary search, remainder divide.
// ----------------------------------------------------------------------------
module wspm_back #(
   parameter int MAX_SEGMENTS = wspm_pkg::MAX_SEGMENTS_DEF,
   parameter int POS_BITS     = wspm_pkg::POS_BITS_DEF,
   parameter int TOTAL_BITS   = wspm_pkg::TOTAL_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  wspm_pkg::item_type  q_item,
   output logic                q_pop,
   wspm_rsp_if.source          rsp_chan
);

   localparam int IDX_W  = $clog2(MAX_SEGMENTS);
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int INC_W  = POS_BITS + wspm_pkg::CN_W;
   localparam int WIDE   = ((INC_W > TOTAL_BITS) ? INC_W : TOTAL_BITS) + 1;
   localparam int DCNT_W = $clog2(TOTAL_BITS + 1);
   localparam int WORD_W = wspm_pkg::CHROM_W + 2 * POS_BITS + TOTAL_BITS;

   logic [WORD_W-1:0] mem [MAX_SEGMENTS];

   wspm_pkg::state_type state_ff, state_in;
   wspm_pkg::item_type  item_ff;
   logic [CNT_W-1:0]      cnt_ff, lo_ff, hi_ff, mid_ff, mid;
   logic [TOTAL_BITS-1:0] total_ff, pos_q, pos_ff, div_ff;
   logic [INC_W-1:0]      inc_ff;
   logic [WIDE-1:0]       sum;
   logic                  ovf;
   logic [WORD_W-1:0]     rd_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  mem_we, srch_more, out_free, q_full, q_beyond;
   logic [POS_BITS-1:0]   b_i, f_i, len_ff, rem_ff, e_begin, e_finish;
   logic [POS_BITS:0]     r2;
   logic [TOTAL_BITS-1:0] e_base;
   logic [wspm_pkg::CHROM_W-1:0] e_chrom;
   logic [DCNT_W-1:0]     dcnt_ff;
   wspm_pkg::status_type  res_status_ff;
   logic [wspm_pkg::SEGNUM_W-1:0] res_seg_ff;
   logic [wspm_pkg::CHROM_W-1:0]  res_chrom_ff;
   logic [wspm_pkg::PPOS_W-1:0]   res_pos_ff;
   logic                  rsp_valid_ff;
   logic [wspm_pkg::STATUS_W-1:0] o_status_ff;
   logic [wspm_pkg::SEGNUM_W-1:0] o_seg_ff;
   logic [wspm_pkg::CHROM_W-1:0]  o_chrom_ff;
   logic [wspm_pkg::PPOS_W-1:0]   o_pos_ff;
   logic [wspm_pkg::PTOT_W-1:0]   o_total_ff;

   assign b_i      = POS_BITS'(item_ff.seg_begin);
   assign f_i      = POS_BITS'(item_ff.seg_finish);
   assign pos_q    = TOTAL_BITS'(q_item.weighted_pos);
   assign q_full   = (cnt_ff == CNT_W'(MAX_SEGMENTS));
   assign q_beyond = (cnt_ff == '0) || (pos_q > total_ff);
   assign sum      = WIDE'(total_ff) + WIDE'(inc_ff);
   assign ovf      = (sum > WIDE'({TOTAL_BITS{1'b1}}));
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign srch_more = ((hi_ff - lo_ff) > CNT_W'(1));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign r2       = {rem_ff, div_ff[TOTAL_BITS-1]};

   assign e_base   = rd_ff[TOTAL_BITS-1:0];
   assign e_finish = rd_ff[TOTAL_BITS +: POS_BITS];
   assign e_begin  = rd_ff[TOTAL_BITS+POS_BITS +: POS_BITS];
   assign e_chrom  = rd_ff[WORD_W-1 -: wspm_pkg::CHROM_W];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wspm_pkg::ST_IDLE: begin
            if (q_valid) begin
               if (q_item.command == wspm_pkg::CMD_ADD) begin
                  state_in = (q_full || q_item.empty) ? wspm_pkg::ST_RESULT
                                                      : wspm_pkg::ST_ADD_MUL;
               end else begin
                  state_in = q_beyond ? wspm_pkg::ST_RESULT : wspm_pkg::ST_SRCH;
               end
            end
         end
         wspm_pkg::ST_ADD_MUL:  state_in = wspm_pkg::ST_ADD_CHK;
         wspm_pkg::ST_ADD_CHK:  state_in = wspm_pkg::ST_RESULT;
         wspm_pkg::ST_SRCH:     state_in = srch_more ? wspm_pkg::ST_SRCH_CMP
                                                     : wspm_pkg::ST_FETCH;
         wspm_pkg::ST_SRCH_CMP: state_in = wspm_pkg::ST_SRCH;
         wspm_pkg::ST_FETCH:    state_in = wspm_pkg::ST_DIV;
         wspm_pkg::ST_DIV: begin
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = wspm_pkg::ST_RESULT;
            end
         end
         wspm_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = wspm_pkg::ST_IDLE;
            end
         end
         default: state_in = wspm_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop   = 1'b0;
      mem_we  = 1'b0;
      rd_addr = lo_ff[IDX_W-1:0];
      unique case (state_ff)
         wspm_pkg::ST_IDLE:    q_pop = q_valid;
         wspm_pkg::ST_ADD_CHK: mem_we = !ovf;
         wspm_pkg::ST_SRCH:    rd_addr = srch_more ? mid[IDX_W-1:0] : lo_ff[IDX_W-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wspm_pkg::ST_IDLE;
         cnt_ff   <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (mem_we) begin
            cnt_ff   <= cnt_ff + CNT_W'(1);
            total_ff <= TOTAL_BITS'(sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cnt_ff[IDX_W-1:0]] <= {item_ff.chrom_index, b_i, f_i, total_ff};
      end
      rd_ff <= mem[rd_addr];
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         wspm_pkg::ST_IDLE: begin
            item_ff      <= q_item;
            pos_ff       <= pos_q;
            lo_ff        <= '0;
            hi_ff        <= cnt_ff;
            res_seg_ff   <= '0;
            res_chrom_ff <= '0;
            res_pos_ff   <= '0;
            if (q_item.command == wspm_pkg::CMD_ADD) begin
               res_status_ff <= q_full ? wspm_pkg::STAT_FULL : wspm_pkg::STAT_EMPTY;
            end else begin
               res_status_ff <= wspm_pkg::STAT_BEYOND;
            end
         end
         wspm_pkg::ST_ADD_MUL: begin
            inc_ff <= INC_W'(f_i - b_i) * INC_W'(item_ff.copy_number);
         end
         wspm_pkg::ST_ADD_CHK: begin
            if (ovf) begin
               res_status_ff <= wspm_pkg::STAT_OVERFLOW;
            end else begin
               res_status_ff <= wspm_pkg::STAT_ADDED;
               res_seg_ff    <= wspm_pkg::SEGNUM_W'(cnt_ff);
            end
         end
         wspm_pkg::ST_SRCH: begin
            mid_ff <= mid;
         end
         wspm_pkg::ST_SRCH_CMP: begin
            if (e_base <= pos_ff) begin
               lo_ff <= mid_ff;
            end else begin
               hi_ff <= mid_ff;
            end
         end
         wspm_pkg::ST_FETCH: begin
            len_ff       <= e_finish - e_begin;
            div_ff       <= pos_ff - e_base;
            rem_ff       <= '0;
            dcnt_ff      <= DCNT_W'(TOTAL_BITS);
            res_chrom_ff <= e_chrom;
            res_seg_ff   <= wspm_pkg::SEGNUM_W'(lo_ff);
            res_pos_ff   <= wspm_pkg::PPOS_W'(e_begin);
         end
         wspm_pkg::ST_DIV: begin
            div_ff  <= div_ff << 1;
            dcnt_ff <= dcnt_ff - DCNT_W'(1);
            if (r2 >= {1'b0, len_ff}) begin
               rem_ff <= POS_BITS'(r2 - {1'b0, len_ff});
            end else begin
               rem_ff <= POS_BITS'(r2);
            end
            if (dcnt_ff == DCNT_W'(1)) begin
               res_status_ff <= wspm_pkg::STAT_MAPPED;
            end
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == wspm_pkg::ST_RESULT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == wspm_pkg::ST_RESULT && out_free) begin
         o_status_ff <= res_status_ff;
         o_seg_ff    <= res_seg_ff;
         o_chrom_ff  <= res_chrom_ff;
         o_total_ff  <= wspm_pkg::PTOT_W'(total_ff);
         if (res_status_ff == wspm_pkg::STAT_MAPPED) begin
            o_pos_ff <= res_pos_ff + wspm_pkg::PPOS_W'(rem_ff);
         end else begin
            o_pos_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = o_status_ff;
   assign rsp_chan.segment_number = o_seg_ff;
   assign rsp_chan.out_chrom      = o_chrom_ff;
   assign rsp_chan.plain_pos      = o_pos_ff;
   assign rsp_chan.weighted_total = o_total_ff;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted segment position mapper: a driver
// and a monitor around the block, with a segment table predictor that
// computes the expected result of every accepted transaction.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      wspm_pkg::status_type          status;
      logic [wspm_pkg::SEGNUM_W-1:0] segment_number;
      logic [wspm_pkg::CHROM_W-1:0]  out_chrom;
      logic [wspm_pkg::PPOS_W-1:0]   plain_pos;
      logic [wspm_pkg::PTOT_W-1:0]   weighted_total;
   } mapping_type;

   localparam int    TABLE_DEPTH = 1024;
   localparam int    CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wspm_req_if req_chan ();
   wspm_rsp_if rsp_chan ();

   weighted_segment_position_mapper dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #2 clock = ~clock;

   wspm_pkg::item_type pending_cmds[$];
   mapping_type        expected_maps[$];

   logic [wspm_pkg::CHROM_W-1:0] seg_chrom[TABLE_DEPTH];
   logic [wspm_pkg::PPOS_W-1:0]  seg_lo[TABLE_DEPTH];
   logic [wspm_pkg::PPOS_W-1:0]  seg_hi[TABLE_DEPTH];
   logic [wspm_pkg::PTOT_W-1:0]  seg_base[TABLE_DEPTH];
   int                           seg_count = 0;
   logic [wspm_pkg::PTOT_W-1:0]  genome_total = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int cycles = 0;

   function automatic mapping_type map_command(wspm_pkg::item_type it);
      mapping_type                 m;
      logic [63:0]                 inc;
      logic [wspm_pkg::PTOT_W-1:0] off;
      int                          lo;
      int                          hi;
      int                          mid;
      m = '{wspm_pkg::STAT_ADDED, '0, '0, '0, '0};
      if (it.command == wspm_pkg::CMD_ADD) begin
         if (seg_count >= TABLE_DEPTH) begin
            m.status = wspm_pkg::STAT_FULL;
         end else if (it.seg_finish <= it.seg_begin) begin
            m.status = wspm_pkg::STAT_EMPTY;
         end else begin
            inc = 64'(it.seg_finish - it.seg_begin) * 64'(it.copy_number);
            if (inc > 64'({wspm_pkg::PTOT_W{1'b1}}) - 64'(genome_total)) begin
               m.status = wspm_pkg::STAT_OVERFLOW;
            end else begin
               seg_chrom[seg_count] = it.chrom_index;
               seg_lo[seg_count]    = it.seg_begin;
               seg_hi[seg_count]    = it.seg_finish;
               seg_base[seg_count]  = genome_total;
               m.segment_number     = wspm_pkg::SEGNUM_W'(seg_count);
               seg_count++;
               genome_total = genome_total + wspm_pkg::PTOT_W'(inc);
            end
         end
      end else if (seg_count == 0 || it.weighted_pos > genome_total) begin
         m.status = wspm_pkg::STAT_BEYOND;
      end else begin
         lo = 0;
         hi = seg_count;
         while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (seg_base[mid] <= it.weighted_pos) lo = mid;
            else hi = mid;
         end
         off = (it.weighted_pos - seg_base[lo])
               % wspm_pkg::PTOT_W'(seg_hi[lo] - seg_lo[lo]);
         m.status         = wspm_pkg::STAT_MAPPED;
         m.segment_number = wspm_pkg::SEGNUM_W'(lo);
         m.out_chrom      = seg_chrom[lo];
         m.plain_pos      = seg_lo[lo] + wspm_pkg::PPOS_W'(off);
      end
      m.weighted_total = genome_total;
      return m;
   endfunction

   function automatic void enqueue_cmd(wspm_pkg::item_type it);
      pending_cmds = {pending_cmds, it};
   endfunction

   function automatic void enqueue_expected(mapping_type m);
      expected_maps = {expected_maps, m};
   endfunction

   function automatic wspm_pkg::item_type add_cmd(logic [7:0] ch, logic [31:0] b,
                                                  logic [31:0] f, logic [7:0] cn);
      wspm_pkg::item_type it;
      it = '0;
      it.command = wspm_pkg::CMD_ADD;
      it.chrom_index = ch;
      it.seg_begin = b;
      it.seg_finish = f;
      it.copy_number = cn;
      it.weighted_pos = 48'({$urandom, $urandom});
      return it;
   endfunction

   function automatic wspm_pkg::item_type map_cmd(logic [47:0] p);
      wspm_pkg::item_type it;
      it = '0;
      it.command = wspm_pkg::CMD_MAP;
      it.chrom_index = 8'($urandom);
      it.seg_begin = $urandom;
      it.seg_finish = $urandom;
      it.copy_number = 8'($urandom);
      it.weighted_pos = p;
      return it;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.command <= 1'b0;
         req_chan.chrom_index <= '0;
         req_chan.seg_begin <= '0;
         req_chan.seg_finish <= '0;
         req_chan.copy_number <= '0;
         req_chan.weighted_pos <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) enqueue_expected(map_command(pending_cmds.pop_front()));
         if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            req_chan.command <= pending_cmds[0].command;
            req_chan.chrom_index <= pending_cmds[0].chrom_index;
            req_chan.seg_begin <= pending_cmds[0].seg_begin;
            req_chan.seg_finish <= pending_cmds[0].seg_finish;
            req_chan.copy_number <= pending_cmds[0].copy_number;
            req_chan.weighted_pos <= pending_cmds[0].weighted_pos;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      mapping_type e;
      cycles <= cycles + 1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_maps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result status %0d", rsp_chan.status);
            end else begin
               e = expected_maps.pop_front();
               if (rsp_chan.status !== e.status || rsp_chan.segment_number !== e.segment_number
                   || rsp_chan.out_chrom !== e.out_chrom || rsp_chan.plain_pos !== e.plain_pos
                   || rsp_chan.weighted_total !== e.weighted_total) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"exp st=%0d seg=%0d chr=%0d pos=%0h tot=%0h ",
                               "got st=%0d seg=%0d chr=%0d pos=%0h tot=%0h"},
                              e.status, e.segment_number, e.out_chrom, e.plain_pos,
                              e.weighted_total, rsp_chan.status, rsp_chan.segment_number,
                              rsp_chan.out_chrom, rsp_chan.plain_pos, rsp_chan.weighted_total);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic wait_drain();
      while (pending_cmds.size() > 0 || req_chan.valid || expected_maps.size() > 0)
         @(posedge clock);
   endtask

   task automatic fill_random(int n, int max_len);
      logic [31:0] b;
      int          k;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               b = $urandom;
               enqueue_cmd(add_cmd(8'($urandom), b,
                  b + $urandom_range(1, max_len), 8'($urandom_range(0, 8))));
            end
            3:  enqueue_cmd(add_cmd(8'($urandom), $urandom, $urandom, 8'($urandom)));
            4:  enqueue_cmd(map_cmd(48'({$urandom, $urandom})));
            default: enqueue_cmd(map_cmd({16'($urandom_range(0, 3) == 0 ?
                     $urandom : 0), 32'($urandom_range(0, 100000))}));
         endcase
      end
   endtask

   initial begin
      int ph;
      int fill_n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed: empty-table map, errors, extremes
      enqueue_cmd(map_cmd('0));
      enqueue_cmd(add_cmd(8'd3, 32'd10, 32'd10, 8'd1));
      enqueue_cmd(add_cmd(8'd3, 32'd20, 32'd10, 8'd1));
      enqueue_cmd(add_cmd(8'hFF, 32'd0, 32'd5, 8'd2));
      enqueue_cmd(add_cmd(8'd0, 32'd100, 32'd107, 8'd0));
      enqueue_cmd(add_cmd(8'hA5, 32'd1000, 32'd1003, 8'd3));
      enqueue_cmd(map_cmd(48'd0));
      enqueue_cmd(map_cmd(48'd9));
      enqueue_cmd(map_cmd(48'd10));
      enqueue_cmd(map_cmd(48'd18));
      enqueue_cmd(map_cmd(48'd19));
      enqueue_cmd(map_cmd(48'd20));
      enqueue_cmd(map_cmd({48{1'b1}}));
      enqueue_cmd(add_cmd(8'h5A, 32'd0, 32'hFFFF_FFFF, 8'hFF));
      enqueue_cmd(add_cmd(8'h11, 32'h8000_0000, 32'hFFFF_FFFF, 8'hFF));
      enqueue_cmd(map_cmd(48'hFE_FFFF_FF00));
      enqueue_cmd(add_cmd(8'h22, 32'd0, 32'hFFFF_FFFF, 8'hFF));
      enqueue_cmd(add_cmd(8'h33, 32'd0, 32'hFFFF_FFFF, 8'hFF));
      enqueue_cmd(map_cmd({48{1'b1}}));
      wait_drain();
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 54 : 14) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 54 : 14) : 0;
         fill_random(ph == 0 ? 160 : 90, ph == 0 ? 200 : 1 << $urandom_range(1, 31));
         wait_drain();
      end
      // fill the table to its limit, then hit it
      send_idle_pct = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      fill_n = TABLE_DEPTH - seg_count + 6;
      for (ph = 0; ph < fill_n; ph++)
         enqueue_cmd(add_cmd(8'($urandom), 32'(ph), 32'(ph + 3), 8'd1));
      wait_drain();
      fill_random(40, 50);
      wait_drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

FILE: weighted_segment_position_mapper.f
hdl/wspm_pkg.sv
hdl/wspm_if.sv
hdl/wspm_front.sv
hdl/wspm_back.sv
hdl/weighted_segment_position_mapper.sv
verif/tb_top.sv
